// ===== hdl/tmcs_pkg.sv =====
// Shared types, widths and register codes for the tile map cull and source block.
package tmcs_pkg;

    // Field widths
    localparam int TILE_W     = 16;
    localparam int FLAG_W     = 8;
    localparam int BASE_W     = 32;
    localparam int POS_W      = 17;
    localparam int SRC_W      = 32;
    localparam int SCR_W      = 12;
    localparam int WIDE_W     = 34;
    localparam int DIV_CNT_W  = 4;

    // Stream payload widths
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 160;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_TILE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH_TILES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd6;

    // Register reset values
    localparam logic [TILE_W-1:0] MAP_TILE_WIDTH_RST  = 16'd16;
    localparam logic [TILE_W-1:0] MAP_TILE_HEIGHT_RST = 16'd16;
    localparam logic [TILE_W-1:0] MAP_WIDTH_TILES_RST = 16'd1;
    localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST    = 12'd320;
    localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST   = 12'd240;

    // Operand select of the shared multiplier
    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_SX,
        MUL_SY
    } tmcs_mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic          div_start;
        logic          mul_en;
        tmcs_mul_sel_t mul_sel;
        logic          chk_x;
        logic          chk_y;
        logic          ld_sx;
        logic          out_load;
    } tmcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic visible;
        logic out_busy;
    } tmcs_sts_t;

endpackage

// ===== hdl/tmcs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module tmcs_div
    import tmcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TILE_W-1:0] dividend,
    input  logic [TILE_W-1:0] divisor,
    output logic              done,
    output logic [TILE_W-1:0] quotient,
    output logic [TILE_W-1:0] remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TILE_W-1:0]    rem_reg;
    logic [TILE_W-1:0]    quo_reg;

    logic [TILE_W:0]      shifted;
    logic [TILE_W:0]      trial;
    logic                 fits;

    // One trial subtraction per cycle
    assign shifted = {rem_reg, quo_reg[TILE_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[TILE_W-1:0] : shifted[TILE_W-1:0];
            quo_reg <= {quo_reg[TILE_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/tmcs_dp.sv =====
// Datapath: registers, map counters, shared multiplier, cull compare, divider, output stage.
module tmcs_dp
    import tmcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  capture,
    input  logic                  first_of_layer,
    input  logic [S_TDATA_W-1:0]  in_data,
    input  tmcs_cmd_t             cmd,
    output tmcs_sts_t             sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [M_TDATA_W-1:0]  out_data
);

    // Configuration registers
    logic signed [TILE_W-1:0] camera_x_reg;
    logic signed [TILE_W-1:0] camera_y_reg;
    logic [TILE_W-1:0]        map_tile_width_reg;
    logic [TILE_W-1:0]        map_tile_height_reg;
    logic [TILE_W-1:0]        map_width_tiles_reg;
    logic [SCR_W-1:0]         screen_width_reg;
    logic [SCR_W-1:0]         screen_height_reg;

    // Map position
    logic [TILE_W-1:0] column_reg;
    logic [TILE_W-1:0] row_reg;
    logic [TILE_W-1:0] col_cur_reg;
    logic [TILE_W-1:0] row_cur_reg;
    logic [TILE_W-1:0] col_use;
    logic [TILE_W-1:0] row_use;
    logic [TILE_W:0]   col_next;

    // Captured item
    logic [TILE_W-1:0] tile_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [TILE_W-1:0] cols_reg;
    logic [TILE_W-1:0] stw_reg;
    logic [TILE_W-1:0] sth_reg;
    logic [TILE_W-1:0] simw_reg;
    logic [BASE_W-1:0] base_reg;

    // Working registers
    logic [SRC_W-1:0]  prod_reg;
    logic [POS_W-1:0]  x_reg;
    logic [POS_W-1:0]  y_reg;
    logic              visx_reg;
    logic [SRC_W-1:0]  sx_reg;

    // Output stage
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Multiplier and compare
    logic [TILE_W-1:0]        mul_a;
    logic [TILE_W-1:0]        mul_b;
    logic [SRC_W-1:0]         mul_out;
    logic signed [WIDE_W-1:0] p_wide;
    logic signed [WIDE_W-1:0] cx_wide;
    logic signed [WIDE_W-1:0] cy_wide;
    logic signed [WIDE_W-1:0] x_diff;
    logic signed [WIDE_W-1:0] y_diff;
    logic signed [WIDE_W-1:0] x_lo;
    logic signed [WIDE_W-1:0] x_hi;
    logic signed [WIDE_W-1:0] y_lo;
    logic signed [WIDE_W-1:0] y_hi;
    logic                     vis_y;
    logic                     cols_zero;

    // Divider
    logic [TILE_W-1:0] div_quo;
    logic [TILE_W-1:0] div_rem;
    logic              div_done;
    logic [TILE_W-1:0] tile_index;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg        <= '0;
            camera_y_reg        <= '0;
            map_tile_width_reg  <= MAP_TILE_WIDTH_RST;
            map_tile_height_reg <= MAP_TILE_HEIGHT_RST;
            map_width_tiles_reg <= MAP_WIDTH_TILES_RST;
            screen_width_reg    <= SCREEN_WIDTH_RST;
            screen_height_reg   <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAMERA_X:        camera_x_reg        <= cfg_data;
                CFG_CAMERA_Y:        camera_y_reg        <= cfg_data;
                CFG_MAP_TILE_WIDTH:  map_tile_width_reg  <= cfg_data;
                CFG_MAP_TILE_HEIGHT: map_tile_height_reg <= cfg_data;
                CFG_MAP_WIDTH_TILES: map_width_tiles_reg <= cfg_data;
                CFG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data[SCR_W-1:0];
                default:             ;
            endcase
        end
    end

    // Column and row counters; a first-of-layer entry starts from the origin
    assign col_use  = first_of_layer ? '0 : column_reg;
    assign row_use  = first_of_layer ? '0 : row_reg;
    assign col_next = {1'b0, col_use} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (capture)
        begin
            if (col_next >= {1'b0, map_width_tiles_reg})
            begin
                column_reg <= '0;
                row_reg    <= row_use + 1'b1;
            end
            else
            begin
                column_reg <= col_next[TILE_W-1:0];
                row_reg    <= row_use;
            end
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            col_cur_reg <= col_use;
            row_cur_reg <= row_use;
            tile_reg    <= in_data[15:0];
            flags_reg   <= in_data[23:16];
            cols_reg    <= in_data[39:24];
            stw_reg     <= in_data[55:40];
            sth_reg     <= in_data[71:56];
            simw_reg    <= in_data[87:72];
            base_reg    <= in_data[119:88];
        end
    end

    // Shared 16x16 multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_X:
            begin
                mul_a = map_tile_width_reg;
                mul_b = col_cur_reg;
            end
            MUL_Y:
            begin
                mul_a = map_tile_height_reg;
                mul_b = row_cur_reg;
            end
            MUL_SX:
            begin
                mul_a = div_rem;
                mul_b = stw_reg;
            end
            MUL_SY:
            begin
                mul_a = div_quo;
                mul_b = sth_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = {{(SRC_W-TILE_W){1'b0}}, mul_a} * {{(SRC_W-TILE_W){1'b0}}, mul_b};

    // Screen position and visibility: lo < product < hi with camera folded into bounds
    assign p_wide  = {{(WIDE_W-SRC_W){1'b0}}, prod_reg};
    assign cx_wide = {{(WIDE_W-TILE_W){camera_x_reg[TILE_W-1]}}, camera_x_reg};
    assign cy_wide = {{(WIDE_W-TILE_W){camera_y_reg[TILE_W-1]}}, camera_y_reg};
    assign x_diff  = p_wide - cx_wide;
    assign y_diff  = p_wide - cy_wide;
    assign x_lo    = cx_wide - {{(WIDE_W-TILE_W){1'b0}}, map_tile_width_reg};
    assign x_hi    = cx_wide + {{(WIDE_W-SCR_W){1'b0}}, screen_width_reg};
    assign y_lo    = cy_wide - {{(WIDE_W-TILE_W){1'b0}}, map_tile_height_reg};
    assign y_hi    = cy_wide + {{(WIDE_W-SCR_W){1'b0}}, screen_height_reg};
    assign vis_y   = (p_wide > y_lo) && (p_wide < y_hi);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_out;
        end
        if (cmd.chk_x)
        begin
            x_reg    <= x_diff[POS_W-1:0];
            visx_reg <= (p_wide > x_lo) && (p_wide < x_hi);
        end
        if (cmd.chk_y)
        begin
            y_reg <= y_diff[POS_W-1:0];
        end
        if (cmd.ld_sx)
        begin
            sx_reg <= cols_zero ? '0 : prod_reg;
        end
    end

    assign cols_zero = (cols_reg == '0);

    // Tile index split into column and row of the tileset
    assign tile_index = tile_reg - 1'b1;

    tmcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (tile_index),
        .divisor   (cols_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Output register; a held result is replaced only once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_data_reg <= {6'b0, flags_reg, base_reg, simw_reg,
                           (cols_zero ? {SRC_W{1'b0}} : prod_reg),
                           sx_reg, y_reg, x_reg};
        end
    end

    assign sts.div_done = div_done;
    assign sts.visible  = visx_reg && vis_y && (tile_reg != '0);
    assign sts.out_busy = m_valid_reg && !out_ready;

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

endmodule

// ===== hdl/tmcs_ctrl.sv =====
// Controller: sequences capture, position multiply, cull, divide and source multiply.
module tmcs_ctrl
    import tmcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      capture,
    output tmcs_cmd_t cmd,
    input  tmcs_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_CHECK,
        S_WAIT_DIV,
        S_MUL_SX,
        S_MUL_SY,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_MUL_X;
            S_MUL_X:    state_next = S_MUL_Y;
            S_MUL_Y:    state_next = S_CHECK;
            S_CHECK:    state_next = sts.visible ? S_WAIT_DIV : S_IDLE;
            S_WAIT_DIV: if (sts.div_done) state_next = S_MUL_SX;
            S_MUL_SX:   state_next = S_MUL_SY;
            S_MUL_SY:   state_next = S_OUT;
            S_OUT:      if (!sts.out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd = '{div_start: 1'b0, mul_en: 1'b0, mul_sel: MUL_X, chk_x: 1'b0,
                chk_y: 1'b0, ld_sx: 1'b0, out_load: 1'b0};
        case (state_reg)
            S_MUL_X:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_X;
                cmd.div_start = 1'b1;
            end
            S_MUL_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y;
                cmd.chk_x   = 1'b1;
            end
            S_CHECK:
            begin
                cmd.chk_y = 1'b1;
            end
            S_MUL_SX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SX;
            end
            S_MUL_SY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SY;
                cmd.ld_sx   = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign capture  = in_ready && in_valid;

endmodule

// ===== hdl/tile_map_cull_and_source_top.sv =====
// Top level of the tile map cull and source block.
//
// Usage: the s_axis channel takes one map tile entry per transaction in
// row-major order; s_axis_tuser marks the first entry of a layer, which
// restarts the column and row counters at the origin. Entries that lie off
// screen or carry tile number zero are dropped; every other entry gives one
// draw command transaction on m_axis.
// The cfg channel writes camera, map tile size, map width and screen size;
// cfg_ready is always high. Write it only while no entry is in flight.
// Sequence: a dropped entry returns the block to idle after the cull check.
// A drawn entry then waits for the bit-serial divide of the tile index by
// the tileset column count, and the draw command is loaded after the divide
// and the source multiplies. One shared 16x16 multiplier forms both the
// screen position and the source offsets.
// A finished command waits in the output register while the next entry is
// taken in; if m_axis stays stalled, the following command holds the block
// before its output load and s_axis_tready stays low.
// Reset clears the counters, sets the cfg registers to their defaults and clears the output valid.
module tile_map_cull_and_source_top
    import tmcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cfg write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tile entries
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tile_number, tile_flags, set_columns, set_tile_width,
    // set_tile_height, set_image_width, image_base
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // first_of_layer
    input  logic                  s_axis_tuser,
    // draw commands
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // screen_x, screen_y, source_x, source_y, source_stride,
    // source_base, draw_flags, zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    tmcs_cmd_t cmd;
    tmcs_sts_t sts;
    logic      capture;

    assign cfg_ready = 1'b1;

    tmcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .capture  (capture),
        .cmd      (cmd),
        .sts      (sts)
    );

    tmcs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .capture        (capture),
        .first_of_layer (s_axis_tuser),
        .in_data        (s_axis_tdata),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata)
    );

    // The block is busy in the cycle after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("entry accepted while previous entry still in work");

    // A command never overwrites a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("output register overwritten while stalled");

    // Source offsets are loaded only from a finished divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld_sx || cmd.out_load) |-> sts.div_done)
        else $error("source offset formed before divide finished");

    // Divider start, multiplier enable and output load never coincide with a capture
    assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> !(cmd.div_start || cmd.out_load || cmd.mul_en))
        else $error("capture during item work");

endmodule
